>>> rtl/core/rational_arith_unit_defines.svh
// Assertion macros used by the rational arithmetic unit top level.
// No dependencies; included by modules that carry concurrent checks.
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rau check failed");

// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rau check failed");

`endif

>>> rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit: widths, opcodes, sequencer states, divider control.
// No dependencies.
`default_nettype none
package rau_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_W = 2 * OPERAND_WIDTH;
    localparam int MAG_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);
    localparam int RES_W  = 33;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CROSS,
        ST_SUM,
        ST_GCD,
        ST_GCDW,
        ST_QN,
        ST_QNW,
        ST_QD,
        ST_QDW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

>>> rtl/core/rational_arith_unit.sv
// Top level of the rational arithmetic unit: sequencer, products, gcd, reduction.
// Depends on rau_pkg, rau_divider and rational_arith_unit_defines.svh.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | opcode, a_num, a_den, b_num, b_den (66->72b)| -
//  m_      | out | res_num, res_den (66 -> 72 bits)            | zero_gcd_error
//
// Sequence: three product states on the one shared multiplier, then each Euclid
// step runs the shared divider, a zero remainder check ends the loop, and each
// of the two final quotients runs the shared divider once more.
// When both raw values are zero the quotients are skipped; how many Euclid steps
// an item takes depends on its data.
// Reset clears the sequencer and output valid; s_tready is high only when idle.
// A held result stalls the sequencer in the output state until m_tready.
`default_nettype none
`include "rational_arith_unit_defines.svh"
module rational_arith_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // opcode[1:0], a_num, a_den, b_num, b_den
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // res_num[32:0], res_den[65:33], zeros
    output logic [0:0]  m_tuser    // zero_gcd_error
);
    import rau_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg;
    logic signed [OPERAND_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    // products held as signed 33-bit terms
    logic signed [MAG_W-1:0] p0_reg, p2_reg;
    logic        n_neg_reg, d_neg_reg;
    logic [MAG_W-1:0] n_mag_reg, d_mag_reg, x_reg, y_reg;
    logic        parity_reg, g_neg_reg;
    logic [RES_W-1:0] rn_reg, rd_reg;
    logic        err_reg;

    logic             div_start;
    logic [MAG_W-1:0] div_a, div_b, div_q, div_r;
    div_ctl_t         dctl;

    logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
    logic signed [PROD_W-1:0] mprod;
    logic signed [MAG_W-1:0] prod, nsum, nv;
    logic [MAG_W-1:0] qmag;
    logic             qneg;

    rau_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .ctl(dctl),
        .quotient(div_q), .remainder(div_r)
    );

    // one shared multiplier: state picks the pair
    // first numerator term, then the cross term, then the denominator
    always_comb begin
        mul_x = an_reg; mul_y = bd_reg;
        case (state_reg)
            ST_MUL: begin
                mul_x = an_reg; mul_y = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            ST_CROSS: begin
                mul_x = ad_reg; mul_y = bn_reg;
            end
            ST_SUM: begin
                mul_x = ad_reg; mul_y = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
            default: begin mul_x = an_reg; mul_y = bd_reg; end
        endcase
        mprod = mul_x * mul_y;
        prod  = MAG_W'(mprod);
        nv   = (op_reg == OP_ADD) ? p0_reg + p2_reg :
               (op_reg == OP_SUB) ? p0_reg - p2_reg : p0_reg;
        nsum = nv;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_CROSS;
            ST_CROSS: state_next = ST_SUM;
            ST_SUM:   state_next = ST_GCD;
            ST_GCD:   state_next = (y_reg == '0) ? ST_QN : ST_GCDW;
            ST_GCDW:  if (dctl.done) state_next = ST_GCD;
            ST_QN:    state_next = (x_reg == '0) ? ST_OUT : ST_QNW;
            ST_QNW:   if (dctl.done) state_next = ST_QD;
            ST_QD:    state_next = ST_QDW;
            ST_QDW:   if (dctl.done) state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0; div_a = x_reg; div_b = y_reg;
        case (state_reg)
            ST_GCD: div_start = (y_reg != '0);
            ST_QN:  begin div_start = (x_reg != '0); div_a = n_mag_reg; div_b = x_reg; end
            ST_QD:  begin div_start = 1'b1; div_a = d_mag_reg; div_b = x_reg; end
            default: div_start = 1'b0;
        endcase
    end

    assign qmag = div_q;
    assign qneg = (state_reg == ST_QNW) ? (n_neg_reg != g_neg_reg) : (d_neg_reg != g_neg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
        case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                op_reg <= op_t'(s_tdata[1:0]);
                an_reg <= s_tdata[2 +: OPERAND_WIDTH];
                ad_reg <= s_tdata[18 +: OPERAND_WIDTH];
                bn_reg <= s_tdata[34 +: OPERAND_WIDTH];
                bd_reg <= s_tdata[50 +: OPERAND_WIDTH];
            end
            ST_MUL:   p0_reg <= prod;
            ST_CROSS: p2_reg <= prod;
            ST_SUM: begin
                n_neg_reg <= nsum[MAG_W-1];
                n_mag_reg <= nsum[MAG_W-1] ? -nsum : nsum;
                x_reg     <= nsum[MAG_W-1] ? -nsum : nsum;
                d_neg_reg <= prod[MAG_W-1];
                d_mag_reg <= prod[MAG_W-1] ? -prod : prod;
                y_reg     <= prod[MAG_W-1] ? -prod : prod;
                parity_reg <= 1'b0;
            end
            ST_GCDW: if (dctl.done) begin
                x_reg <= y_reg; y_reg <= div_r; parity_reg <= ~parity_reg;
            end
            ST_QN: begin
                g_neg_reg <= parity_reg ? d_neg_reg : n_neg_reg;
                err_reg <= (x_reg == '0);
                rn_reg <= '0; rd_reg <= '0;
            end
            ST_QNW: if (dctl.done) rn_reg <= RES_W'(qneg ? -qmag : qmag);
            ST_QDW: if (dctl.done) rd_reg <= RES_W'(qneg ? -qmag : qmag);
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'b0, rd_reg, rn_reg};
    assign m_tuser  = err_reg;

    `RAU_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_tready, !m_tvalid)
    `RAU_ASSERT_NXT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RAU_ASSERT_IMP(a_div_quiet, aclk, aresetn, dctl.busy, !dctl.start)
endmodule
`default_nettype wire

>>> rtl/core/rau_divider.sv
// Restoring shift-subtract divider on unsigned magnitudes, one bit per cycle.
// Depends on rau_pkg.
`default_nettype none
module rau_divider (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      start,
    input  wire [rau_pkg::MAG_W-1:0] dividend,
    input  wire [rau_pkg::MAG_W-1:0] divisor,
    output rau_pkg::div_ctl_t        ctl,
    output logic [rau_pkg::MAG_W-1:0] quotient,
    output logic [rau_pkg::MAG_W-1:0] remainder
);
    import rau_pkg::*;

    logic [MAG_W-1:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [MAG_W:0]   trial;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        trial = '0;
        if (start) begin
            q_next = dividend; r_next = '0; d_next = divisor;
            cnt_next = CNT_W'(MAG_W); busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in next dividend bit, subtract if it fits
            trial = {r_reg, q_reg[MAG_W-1]} - {1'b0, d_reg};
            if (!trial[MAG_W]) begin
                r_next = trial[MAG_W-1:0];
                q_next = {q_reg[MAG_W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[MAG_W-2:0], q_reg[MAG_W-1]};
                q_next = {q_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire
